>>> rtl/core/fid_pkg.sv
`timescale 1ns / 1ps

package fid_pkg;

   // Field widths
   localparam int MAG_W    = 15;
   localparam int SPAN_W   = 16;
   localparam int RATE_W   = 8;
   localparam int PERIOD_W = 10;
   localparam int TIME_W   = 32;
   localparam int CSR_W    = 16;
   localparam int CSR_IDX_W = 2;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMPACT_THRESHOLD = 2'd0,
      CSR_IDLE_THRESHOLD   = 2'd1,
      CSR_IDLE_SPAN_MS     = 2'd2,
      CSR_SAMPLE_RATE_HZ   = 2'd3
   } csr_index_type;

   // Reset values of the registers
   localparam logic [MAG_W-1:0]  IMPACT_RESET = 15'd250;
   localparam logic [MAG_W-1:0]  IDLE_RESET   = 15'd120;
   localparam logic [SPAN_W-1:0] SPAN_RESET   = 16'd2000;
   localparam logic [RATE_W-1:0] RATE_RESET   = 8'd100;

   // Period derived from the reset rate: 1000 / 100 and 1000 % 100
   localparam logic [PERIOD_W-1:0] PERIOD_RESET     = 10'd10;
   localparam logic [RATE_W-1:0]   PERIOD_REM_RESET = 8'd0;

   // Period used when the rate register holds zero
   localparam logic [PERIOD_W-1:0] PERIOD_DEFAULT = 10'd10;

   // Milliseconds per second, the dividend of the period divider
   localparam logic [PERIOD_W-1:0] MS_PER_SEC = 10'd1000;

   // Extra window after the idle span before an event is dropped
   localparam logic [SPAN_W:0] DROP_MARGIN_MS = 17'd100;

   localparam logic [SPAN_W-1:0] IDLE_SAT = 16'hFFFF;
   localparam logic [MAG_W-1:0]  MAG_SAT  = 15'h7FFF;

   typedef struct packed {
      logic signed [15:0] accel_x;
      logic signed [15:0] accel_y;
      logic signed [15:0] accel_z;
   } req_type;

   typedef struct packed {
      logic [TIME_W-1:0] event_time_ms;
      logic [MAG_W-1:0]  peak_magnitude;
      logic [SPAN_W-1:0] idle_time_ms;
   } rsp_type;

   typedef struct packed {
      logic                 we;
      csr_index_type        index;
      logic [CSR_W-1:0]     wdata;
   } csr_type;

   // Period status from the divider to the back end
   typedef struct packed {
      logic                busy;
      logic [PERIOD_W-1:0] period_ms;
      logic [RATE_W-1:0]   period_rem;
      logic [RATE_W-1:0]   rate;
   } period_type;

   // Absolute value of one axis, saturated to the magnitude range
   function automatic logic [MAG_W-1:0] axis_abs(input logic signed [15:0] v);
      logic [15:0] neg;
      neg = 16'(-v);
      if (v == 16'sh8000) begin
         return MAG_SAT;
      end else if (v[15]) begin
         return neg[MAG_W-1:0];
      end else begin
         return v[MAG_W-1:0];
      end
   endfunction

endpackage

>>> rtl/core/fid_front.sv
`timescale 1ns / 1ps

module fid_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  fid_pkg::req_type          req_data,
   output logic                      q_valid,
   output logic [fid_pkg::MAG_W-1:0] q_mag,
   input  logic                      q_pop
);

   logic [fid_pkg::MAG_W-1:0] mem_ff [2];
   logic                      wr_ptr_ff, wr_ptr_in;
   logic                      rd_ptr_ff, rd_ptr_in;
   logic [1:0]                count_ff, count_in;
   logic [fid_pkg::MAG_W-1:0] mag_x, mag_y, mag_z, mag_xy, mag;
   logic                      push;

   // Largest absolute axis value
   always_comb begin
      mag_x  = fid_pkg::axis_abs(req_data.accel_x);
      mag_y  = fid_pkg::axis_abs(req_data.accel_y);
      mag_z  = fid_pkg::axis_abs(req_data.accel_z);
      mag_xy = (mag_y > mag_x) ? mag_y : mag_x;
      mag    = (mag_z > mag_xy) ? mag_z : mag_xy;
   end

   assign req_ready = (count_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != 2'd0);
   assign q_mag     = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !q_pop) begin
         count_in = count_ff + 2'd1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= mag;
      end
   end

endmodule

>>> rtl/core/fid_period.sv
`timescale 1ns / 1ps

module fid_period (
   input  logic                clock,
   input  logic                reset,
   input  fid_pkg::csr_type    csr,
   output fid_pkg::period_type period
);

   logic [fid_pkg::RATE_W-1:0]   rate_ff, rate_in;
   logic                         busy_ff, busy_in;
   logic [3:0]                   cnt_ff, cnt_in;
   logic [fid_pkg::RATE_W-1:0]   rem_ff, rem_in;
   logic [fid_pkg::PERIOD_W-1:0] quo_ff, quo_in;
   logic [fid_pkg::PERIOD_W-1:0] period_ms_ff, period_ms_in;
   logic [fid_pkg::RATE_W-1:0]   period_rem_ff, period_rem_in;
   logic [fid_pkg::RATE_W:0]     r_shift, r_sub;
   logic                         ge;
   logic                         rate_wr;

   assign rate_wr = csr.we && (csr.index == fid_pkg::CSR_SAMPLE_RATE_HZ);

   // One quotient bit per cycle, most significant first
   always_comb begin
      r_shift = {rem_ff, fid_pkg::MS_PER_SEC[cnt_ff]};
      ge      = (r_shift >= {1'b0, rate_ff});
      r_sub   = ge ? (r_shift - {1'b0, rate_ff}) : r_shift;

      rate_in       = rate_ff;
      busy_in       = busy_ff;
      cnt_in        = cnt_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      period_ms_in  = period_ms_ff;
      period_rem_in = period_rem_ff;

      if (rate_wr) begin
         rate_in = csr.wdata[fid_pkg::RATE_W-1:0];
         rem_in  = '0;
         quo_in  = '0;
         cnt_in  = 4'(fid_pkg::PERIOD_W - 1);
         if (csr.wdata[fid_pkg::RATE_W-1:0] == '0) begin
            busy_in       = 1'b0;
            period_ms_in  = fid_pkg::PERIOD_DEFAULT;
            period_rem_in = '0;
         end else begin
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         rem_in = r_sub[fid_pkg::RATE_W-1:0];
         quo_in = {quo_ff[fid_pkg::PERIOD_W-2:0], ge};
         cnt_in = cnt_ff - 4'd1;
         if (cnt_ff == 4'd0) begin
            busy_in       = 1'b0;
            period_ms_in  = {quo_ff[fid_pkg::PERIOD_W-2:0], ge};
            period_rem_in = r_sub[fid_pkg::RATE_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff       <= fid_pkg::RATE_RESET;
         busy_ff       <= 1'b0;
         cnt_ff        <= '0;
         period_ms_ff  <= fid_pkg::PERIOD_RESET;
         period_rem_ff <= fid_pkg::PERIOD_REM_RESET;
      end else begin
         rate_ff       <= rate_in;
         busy_ff       <= busy_in;
         cnt_ff        <= cnt_in;
         period_ms_ff  <= period_ms_in;
         period_rem_ff <= period_rem_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign period.busy       = busy_ff;
   assign period.period_ms  = period_ms_ff;
   assign period.period_rem = period_rem_ff;
   assign period.rate       = rate_ff;

endmodule

>>> rtl/core/fid_back.sv
`timescale 1ns / 1ps

module fid_back (
   input  logic                      clock,
   input  logic                      reset,
   input  fid_pkg::csr_type          csr,
   input  fid_pkg::period_type       period,
   input  logic                      q_valid,
   input  logic [fid_pkg::MAG_W-1:0] q_mag,
   output logic                      q_pop,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output fid_pkg::rsp_type          rsp_data
);

   logic [fid_pkg::MAG_W-1:0]  impact_thr_ff, idle_thr_ff;
   logic [fid_pkg::SPAN_W-1:0] span_ff;

   logic                        tracking_ff, tracking_in;
   logic [fid_pkg::MAG_W-1:0]   peak_ff, peak_in;
   logic [fid_pkg::TIME_W-1:0]  peak_time_ff, peak_time_in;
   logic [fid_pkg::TIME_W-1:0]  elapsed_ff, elapsed_in;
   logic [fid_pkg::SPAN_W-1:0]  idle_ff, idle_in;
   logic [fid_pkg::TIME_W-1:0]  clock_ms_ff, clock_ms_in;
   logic [fid_pkg::RATE_W-1:0]  rsum_ff, rsum_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   fid_pkg::rsp_type            rsp_data_ff, rsp_data_in;

   logic [fid_pkg::RATE_W:0]    rsum_add;
   logic                        carry;
   logic [fid_pkg::TIME_W-1:0]  step_ms, elapsed_step;
   logic [fid_pkg::SPAN_W:0]    idle_add;
   logic [fid_pkg::SPAN_W-1:0]  idle_next;
   logic                        peak_upd, emit, drop;

   assign q_pop = q_valid && !period.busy && (!rsp_valid_ff || rsp_ready);

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         impact_thr_ff <= fid_pkg::IMPACT_RESET;
         idle_thr_ff   <= fid_pkg::IDLE_RESET;
         span_ff       <= fid_pkg::SPAN_RESET;
      end else if (csr.we) begin
         case (csr.index)
            fid_pkg::CSR_IMPACT_THRESHOLD: begin
               impact_thr_ff <= csr.wdata[fid_pkg::MAG_W-1:0];
            end
            fid_pkg::CSR_IDLE_THRESHOLD: begin
               idle_thr_ff <= csr.wdata[fid_pkg::MAG_W-1:0];
            end
            fid_pkg::CSR_IDLE_SPAN_MS: begin
               span_ff <= csr.wdata[fid_pkg::SPAN_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      // Clock step with carried remainder
      rsum_add = {1'b0, rsum_ff} + {1'b0, period.period_rem};
      carry    = (period.period_rem != '0) && (period.rate != '0)
                 && (rsum_add >= {1'b0, period.rate});
      step_ms  = fid_pkg::TIME_W'(period.period_ms) + fid_pkg::TIME_W'(carry);

      clock_ms_in  = clock_ms_ff;
      rsum_in      = rsum_ff;
      tracking_in  = tracking_ff;
      peak_in      = peak_ff;
      peak_time_in = peak_time_ff;
      elapsed_in   = elapsed_ff;
      idle_in      = idle_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;

      elapsed_step = elapsed_ff + step_ms;
      peak_upd     = (q_mag > peak_ff);
      idle_add     = {1'b0, idle_ff} + fid_pkg::SPAN_W'(period.period_ms);
      idle_next    = (q_mag <= idle_thr_ff)
                     ? (idle_add[fid_pkg::SPAN_W] ? fid_pkg::IDLE_SAT
                                                  : idle_add[fid_pkg::SPAN_W-1:0])
                     : '0;
      emit = 1'b0;
      drop = 1'b0;

      if (csr.we && (csr.index == fid_pkg::CSR_SAMPLE_RATE_HZ)) begin
         rsum_in = '0;
      end

      if (q_pop) begin
         clock_ms_in = clock_ms_ff + step_ms;
         if (period.period_rem != '0 && period.rate != '0) begin
            rsum_in = carry ? 8'(rsum_add - {1'b0, period.rate})
                            : rsum_add[fid_pkg::RATE_W-1:0];
         end

         if (!tracking_ff) begin
            if (q_mag >= impact_thr_ff) begin
               tracking_in  = 1'b1;
               peak_in      = q_mag;
               peak_time_in = clock_ms_in;
               elapsed_in   = '0;
               idle_in      = '0;
            end
         end else begin
            if (peak_upd) begin
               peak_in      = q_mag;
               peak_time_in = clock_ms_in;
               elapsed_in   = '0;
            end else begin
               elapsed_in   = elapsed_step;
            end
            idle_in = idle_next;
            emit    = (idle_next >= span_ff);
            drop    = !emit && (q_mag < impact_thr_ff) && (idle_next == '0)
                      && (elapsed_in > fid_pkg::TIME_W'({1'b0, span_ff}
                                                        + fid_pkg::DROP_MARGIN_MS));
            if (emit) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.event_time_ms  = peak_time_in;
               rsp_data_in.peak_magnitude = peak_in;
               rsp_data_in.idle_time_ms   = idle_next;
            end
            if (emit || drop) begin
               tracking_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tracking_ff  <= 1'b0;
         clock_ms_ff  <= '0;
         rsum_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tracking_ff  <= tracking_in;
         clock_ms_ff  <= clock_ms_in;
         rsum_ff      <= rsum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Event payload is only read while tracking, which start overwrites
   always_ff @(posedge clock) begin
      peak_ff      <= peak_in;
      peak_time_ff <= peak_time_in;
      elapsed_ff   <= elapsed_in;
      idle_ff      <= idle_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> rtl/core/fall_impact_idle_detector_top.sv
`timescale 1ns / 1ps

// Channel  | Handshake              | Payload                         | Transfer when
// ---------+------------------------+---------------------------------+-------------------
// req      | req_valid / req_ready  | req_data (accel_x, _y, _z)      | valid && ready
// rsp      | rsp_valid / rsp_ready  | rsp_data (time, peak, idle ms)  | valid && ready
// csr      | csr_we                 | csr_index, csr_wdata            | csr_we high
//
// One sample per cycle is sustained while rsp_ready stays high and no divide runs;
// the step is one 32-bit clock add and the tracking compares in the back end.
// A transferred sample waits in the queue; once popped, its response is registered.
// A write of the sample rate starts a bit-serial divider (1000 / rate);
// the back end holds samples in the queue until the new period is ready.
// Reset is synchronous and clears all control state; the two-entry queue lets the
// front keep taking samples while a response waits on rsp_ready.

module fall_impact_idle_detector_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  fid_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output fid_pkg::rsp_type                  rsp_data,
   input  logic                              csr_we,
   input  logic [fid_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [fid_pkg::CSR_W-1:0]         csr_wdata
);

   fid_pkg::csr_type          csr;
   fid_pkg::period_type       period;
   logic                      q_valid;
   logic [fid_pkg::MAG_W-1:0] q_mag;
   logic                      q_pop;

   // Bundle the write port for both consumers
   assign csr.we    = csr_we;
   assign csr.index = fid_pkg::csr_index_type'(csr_index);
   assign csr.wdata = csr_wdata;

   // Front: take each sample, reduce it to a magnitude and queue it
   fid_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_mag     (q_mag),
      .q_pop     (q_pop)
   );

   // Sample period from the rate register
   fid_period u_period (
      .clock  (clock),
      .reset  (reset),
      .csr    (csr),
      .period (period)
   );

   // Back: advance the ms clock, track the event and register the report
   fid_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr),
      .period    (period),
      .q_valid   (q_valid),
      .q_mag     (q_mag),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

>>> rtl/core/fid_checker.sv
`timescale 1ns / 1ps

module fid_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input fid_pkg::rsp_type rsp_data
);

   // No stale response survives reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // The empty queue takes two samples after reset
   assert property (@(posedge clock) reset |=> req_ready ##1 (reset || req_ready))
      else $error("request side stalled right after reset");

   // A stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // After reset, a response first needs a queued sample
   assert property (@(posedge clock) reset |=> !rsp_valid ##1 (reset || !rsp_valid))
      else $error("response too early after reset");

endmodule

bind fall_impact_idle_detector_top fid_checker u_fid_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
